[src/krp_pkg.sv]
// shared types, constants and the control store for the key range partition router
// no dependencies; the design files refer to this package by scoped names, the testbench files import it
package krp_pkg;

	localparam int KEY_W       = 31;
	localparam int VAL_W       = 32;
	localparam int SHARD_W     = 4;
	localparam int WC_W        = 5;
	localparam int CMD_W       = 2;
	localparam int CFG_W       = KEY_W;
	localparam int CFG_IDX_W   = 1;
	localparam int RESULT_CAP  = 16;
	localparam int CNT_W       = $clog2(RESULT_CAP + 1);
	localparam int DIV_CNT_W   = $clog2(KEY_W + 1);

	localparam logic [WC_W-1:0]  MAX_WORKERS = WC_W'(16);
	localparam logic [KEY_W-1:0] KPW_RESET   = KEY_W'(1024);
	localparam logic [WC_W-1:0]  WC_RESET    = WC_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_GET   = 2'd0,
		CMD_PUT   = 2'd1,
		CMD_RANGE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KPW = 1'b0,
		REG_WC  = 1'b1
	} cfg_idx_t;

	// program steps
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DIV_INIT = 3'd1,
		ST_DIV_RUN  = 3'd2,
		ST_PLACE    = 3'd3,
		ST_SEG      = 3'd4,
		ST_SEG_DONE = 3'd5,
		ST_POINT    = 3'd6
	} step_t;

	// jump conditions: taken goes to target, otherwise next step
	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_INPUT = 3'd2,
		C_DROP     = 3'd3,
		C_DIV_MORE = 3'd4,
		C_POINT    = 3'd5,
		C_SEG_MORE = 3'd6
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  div_init;
		logic  div_step;
		logic  place;
		logic  emit_seg;
		logic  emit_point;
		logic  wait_out;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic in_ready;
		logic div_init;
		logic div_step;
		logic place;
		logic emit_seg;
		logic emit_point;
	} krp_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic drop;
		logic div_more;
		logic point;
		logic seg_more;
		logic out_free;
	} krp_status_t;

	// control store
	function automatic ucode_t ucode_word(input step_t pc);
		ucode_t w;
		w = '{in_ready: 1'b0, div_init: 1'b0, div_step: 1'b0, place: 1'b0,
			emit_seg: 1'b0, emit_point: 1'b0, wait_out: 1'b0,
			cond: C_ALWAYS, target: ST_IDLE};
		case (pc)
			ST_IDLE: begin
				w.in_ready = 1'b1;
				w.cond     = C_NO_INPUT;
				w.target   = ST_IDLE;
			end
			ST_DIV_INIT: begin
				w.div_init = 1'b1;
				w.cond     = C_DROP;
				w.target   = ST_IDLE;
			end
			ST_DIV_RUN: begin
				w.div_step = 1'b1;
				w.cond     = C_DIV_MORE;
				w.target   = ST_DIV_RUN;
			end
			ST_PLACE: begin
				w.place  = 1'b1;
				w.cond   = C_POINT;
				w.target = ST_POINT;
			end
			ST_SEG: begin
				w.emit_seg = 1'b1;
				w.wait_out = 1'b1;
				w.cond     = C_SEG_MORE;
				w.target   = ST_SEG;
			end
			ST_SEG_DONE: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			ST_POINT: begin
				w.emit_point = 1'b1;
				w.wait_out   = 1'b1;
				w.cond       = C_ALWAYS;
				w.target     = ST_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[src/krp_in_if.sv]
// operation channel: valid/ready handshake carrying one key-value operation per beat
// depends on krp_pkg for field widths
interface krp_in_if;
	logic                        valid;
	logic                        ready;
	logic [krp_pkg::CMD_W-1:0]   command;
	logic [krp_pkg::KEY_W-1:0]   key_low;
	logic [krp_pkg::KEY_W-1:0]   key_high;
	logic [krp_pkg::VAL_W-1:0]   put_value;
	logic                        txn_last;

	modport source (output valid, command, key_low, key_high, put_value, txn_last,
		input ready);
	modport sink (input valid, command, key_low, key_high, put_value, txn_last,
		output ready);
endinterface

[src/krp_out_if.sv]
// routed result channel: valid/ready handshake carrying one sub-operation per beat
// depends on krp_pkg for field widths
interface krp_out_if;
	logic                        valid;
	logic                        ready;
	logic [krp_pkg::SHARD_W-1:0] shard_index;
	logic [krp_pkg::CMD_W-1:0]   out_command;
	logic [krp_pkg::KEY_W-1:0]   begin_key;
	logic [krp_pkg::KEY_W-1:0]   end_key;
	logic [krp_pkg::VAL_W-1:0]   out_value;
	logic                        shard_overflow;
	logic                        run_last;
	logic                        txn_end;

	modport source (output valid, shard_index, out_command, begin_key, end_key, out_value,
		shard_overflow, run_last, txn_end, input ready);
	modport sink (input valid, shard_index, out_command, begin_key, end_key, out_value,
		shard_overflow, run_last, txn_end, output ready);
endinterface

[src/krp_divider.sv]
// restoring divider, one quotient bit per step, for key / keys-per-worker
// depends on krp_pkg for the key width
module krp_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      init,
	input  logic                      step,
	input  logic [krp_pkg::KEY_W-1:0] dividend,
	input  logic [krp_pkg::KEY_W-1:0] divisor,
	output logic [krp_pkg::KEY_W-1:0] quotient,
	output logic [krp_pkg::KEY_W-1:0] remainder,
	output logic                      more
);

	logic [krp_pkg::KEY_W-1:0]     rem_q;
	logic [krp_pkg::KEY_W-1:0]     quo_q;
	logic [krp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [krp_pkg::KEY_W:0]       partial;
	logic [krp_pkg::KEY_W:0]       trial;
	logic                          fits;

	// shift the next dividend bit into the partial remainder
	assign partial = {rem_q, quo_q[krp_pkg::KEY_W-1]};
	assign trial   = partial - {1'b0, divisor};
	assign fits    = partial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= krp_pkg::DIV_CNT_W'(krp_pkg::KEY_W);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= fits ? trial[krp_pkg::KEY_W-1:0] : partial[krp_pkg::KEY_W-1:0];
			quo_q <= {quo_q[krp_pkg::KEY_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign more      = cnt_q != krp_pkg::DIV_CNT_W'(1);

endmodule

[src/krp_sequencer.sv]
// step counter and control store: one control word per cycle, cond. jumps, held on a stall
// depends on krp_pkg for the program, control and status structs
module krp_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  krp_pkg::krp_status_t status,
	output krp_pkg::krp_ctrl_t   ctrl
);

	krp_pkg::step_t  pc_q;
	krp_pkg::ucode_t cw;
	logic            blocked;
	logic            hit;

	assign cw      = krp_pkg::ucode_word(pc_q);
	// an emitting step holds while the result register is full and not being taken
	assign blocked = cw.wait_out && !status.out_free;

	always_comb begin
		case (cw.cond)
			krp_pkg::C_NEVER:    hit = 1'b0;
			krp_pkg::C_ALWAYS:   hit = 1'b1;
			krp_pkg::C_NO_INPUT: hit = !status.in_valid;
			krp_pkg::C_DROP:     hit = status.drop;
			krp_pkg::C_DIV_MORE: hit = status.div_more;
			krp_pkg::C_POINT:    hit = status.point;
			krp_pkg::C_SEG_MORE: hit = status.seg_more;
			default:             hit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= krp_pkg::ST_IDLE;
		end else if (!blocked) begin
			pc_q <= hit ? cw.target : krp_pkg::step_t'(pc_q + 3'd1);
		end
	end

	assign ctrl.in_ready   = cw.in_ready;
	assign ctrl.div_init   = cw.div_init;
	assign ctrl.div_step   = cw.div_step;
	assign ctrl.place      = cw.place;
	assign ctrl.emit_seg   = cw.emit_seg && !blocked;
	assign ctrl.emit_point = cw.emit_point && !blocked;

endmodule

[src/key_range_partition_router.sv]
// key range partition router: routes key-value operations to the worker shard owning the key
// depends on krp_pkg, krp_in_if, krp_out_if, krp_divider and krp_sequencer
//
// Operations arrive on req (valid/ready); one beat is accepted when both are high. Get and
// put give one result beat on rsp, a range read gives one beat per shard it touches with
// its bounds clamped to the request, plus one flagged beat for any part past the last
// shard (at most sixteen beats). Command 3 and reversed ranges give nothing. run_last marks
// the final beat of an operation, txn_end repeats txn_last on that beat.
// The key is divided by keys_per_worker in a bit-serial divider before any beat is formed; a
// dropped operation returns to idle without stepping the divider. req.ready is high only
// between operations.
// Results sit in an output register; a stalled rsp holds the beat and the sequencer waits
// on its emitting step, nothing is lost. The next operation is accepted while the last
// result still waits to be taken.
// Reset (arst_n low) empties the output register, returns the sequencer to idle and loads
// keys_per_worker = 1024 and worker_count = 16. Write registers only while idle.
module key_range_partition_router (
	input  logic                          clk,
	input  logic                          arst_n,
	krp_in_if.sink                        req,
	krp_out_if.source                     rsp,
	input  logic                          cfg_wr_en,
	input  krp_pkg::cfg_idx_t             cfg_index,
	input  logic [krp_pkg::CFG_W-1:0]     cfg_data
);

	// configuration
	logic [krp_pkg::KEY_W-1:0] kpw_q;
	logic [krp_pkg::WC_W-1:0]  wc_q;
	logic [krp_pkg::KEY_W-1:0] kpw_eff;
	logic [krp_pkg::WC_W-1:0]  wc_eff;

	// held operation
	krp_pkg::cmd_t             cmd_q;
	logic [krp_pkg::KEY_W-1:0] klo_q;
	logic [krp_pkg::KEY_W-1:0] khi_q;
	logic [krp_pkg::VAL_W-1:0] val_q;
	logic                      tl_q;

	// walk state
	logic [krp_pkg::KEY_W-1:0]   blk_q;
	logic [krp_pkg::SHARD_W-1:0] shard_q;
	logic                        ovf_q;
	logic                        tail_q;
	logic [krp_pkg::CNT_W-1:0]   cnt_q;

	// result register
	logic                          out_valid_q;
	logic [krp_pkg::SHARD_W-1:0]   o_shard_q;
	krp_pkg::cmd_t                 o_cmd_q;
	logic [krp_pkg::KEY_W-1:0]     o_begin_q;
	logic [krp_pkg::KEY_W-1:0]     o_end_q;
	logic [krp_pkg::VAL_W-1:0]     o_value_q;
	logic                          o_ovf_q;
	logic                          o_last_q;
	logic                          o_txn_q;

	krp_pkg::krp_ctrl_t   ctrl;
	krp_pkg::krp_status_t status;

	logic [krp_pkg::KEY_W-1:0] quo;
	logic [krp_pkg::KEY_W-1:0] rem;
	logic                      div_more;
	logic                      accept;
	logic                      out_free;

	logic [krp_pkg::KEY_W:0]   blk_end;
	logic                      contains;
	logic                      at_top;
	logic                      cap;
	logic                      flagged;
	logic                      seg_last;
	logic [krp_pkg::KEY_W-1:0] seg_begin;
	logic [krp_pkg::KEY_W-1:0] seg_end;

	assign kpw_eff = (kpw_q == '0) ? krp_pkg::KEY_W'(1) : kpw_q;
	assign wc_eff  = (wc_q > krp_pkg::MAX_WORKERS) ? krp_pkg::MAX_WORKERS : wc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpw_q <= krp_pkg::KPW_RESET;
			wc_q  <= krp_pkg::WC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				krp_pkg::REG_KPW: kpw_q <= cfg_data[krp_pkg::KEY_W-1:0];
				krp_pkg::REG_WC:  wc_q  <= cfg_data[krp_pkg::WC_W-1:0];
				default: ;
			endcase
		end
	end

	krp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	krp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (ctrl.div_init),
		.step      (ctrl.div_step),
		.dividend  (klo_q),
		.divisor   (kpw_eff),
		.quotient  (quo),
		.remainder (rem),
		.more      (div_more)
	);

	assign req.ready = ctrl.in_ready;
	assign accept    = req.valid && ctrl.in_ready;
	assign out_free  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= krp_pkg::cmd_t'(req.command);
			klo_q <= req.key_low;
			khi_q <= req.key_high;
			val_q <= req.put_value;
			tl_q  <= req.txn_last;
		end
	end

	// segment of the current block, clamped to the requested range
	assign blk_end   = {1'b0, blk_q} + {1'b0, kpw_eff} - 1'b1;
	assign contains  = blk_end >= {1'b0, khi_q};
	assign at_top    = {1'b0, shard_q} == (wc_eff - 1'b1);
	assign cap       = cnt_q == krp_pkg::CNT_W'(krp_pkg::RESULT_CAP - 1);
	assign flagged   = ovf_q || tail_q;
	assign seg_last  = flagged || contains || cap;
	assign seg_begin = flagged ? (tail_q ? blk_q : klo_q)
		: ((blk_q > klo_q) ? blk_q : klo_q);
	assign seg_end   = (flagged || contains) ? khi_q : blk_end[krp_pkg::KEY_W-1:0];

	assign status.in_valid = req.valid;
	assign status.drop     = (cmd_q == krp_pkg::CMD_NONE)
		|| ((cmd_q == krp_pkg::CMD_RANGE) && (klo_q > khi_q));
	assign status.div_more = div_more;
	assign status.point    = (cmd_q == krp_pkg::CMD_GET) || (cmd_q == krp_pkg::CMD_PUT);
	assign status.seg_more = !seg_last;
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.place) begin
			tail_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.emit_seg) begin
			cnt_q <= cnt_q + 1'b1;
			if (!seg_last && at_top) begin
				tail_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.place) begin
			blk_q   <= klo_q - rem;
			shard_q <= quo[krp_pkg::SHARD_W-1:0];
			ovf_q   <= quo >= krp_pkg::KEY_W'(wc_eff);
		end else if (ctrl.emit_seg && !seg_last) begin
			// next block; past the top shard this is the first unrouted key
			blk_q <= blk_q + kpw_eff;
			if (!at_top) begin
				shard_q <= shard_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_seg || ctrl.emit_point) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_point) begin
			o_shard_q <= ovf_q ? '0 : shard_q;
			o_cmd_q   <= cmd_q;
			o_begin_q <= klo_q;
			o_end_q   <= klo_q;
			o_value_q <= (cmd_q == krp_pkg::CMD_PUT) ? val_q : '0;
			o_ovf_q   <= ovf_q;
			o_last_q  <= 1'b1;
			o_txn_q   <= tl_q;
		end else if (ctrl.emit_seg) begin
			o_shard_q <= flagged ? '0 : shard_q;
			o_cmd_q   <= krp_pkg::CMD_RANGE;
			o_begin_q <= seg_begin;
			o_end_q   <= seg_end;
			o_value_q <= '0;
			o_ovf_q   <= flagged;
			o_last_q  <= seg_last;
			o_txn_q   <= seg_last && tl_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.shard_index    = o_shard_q;
	assign rsp.out_command    = o_cmd_q;
	assign rsp.begin_key      = o_begin_q;
	assign rsp.end_key        = o_end_q;
	assign rsp.out_value      = o_value_q;
	assign rsp.shard_overflow = o_ovf_q;
	assign rsp.run_last       = o_last_q;
	assign rsp.txn_end        = o_txn_q;

	a_ovf_shard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.shard_overflow |-> rsp.shard_index == '0)
		else $error("flagged beat carries a shard index");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.begin_key <= rsp.end_key)
		else $error("sub-range begin above end");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit_seg |-> cnt_q < krp_pkg::CNT_W'(krp_pkg::RESULT_CAP))
		else $error("range split beyond result cap");

	a_txn_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.txn_end |-> rsp.run_last)
		else $error("txn_end on a beat that is not last");

endmodule

[verif/krp_route_checker.sv]
`timescale 1ns / 100ps
// route checker for the key range partition router: watches the operation and result channels
// and the register port, predicts the routed beats of each operation and compares them in order
// depends on krp_pkg, krp_in_if and krp_out_if
module krp_route_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	krp_in_if                         req,
	krp_out_if                        rsp,
	input  logic                      cfg_wr_en,
	input  krp_pkg::cfg_idx_t         cfg_index,
	input  logic [krp_pkg::CFG_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        beats_pending
);
	import krp_pkg::*;

	typedef struct packed {
		logic [SHARD_W-1:0] shard;
		cmd_t               cmd;
		logic [KEY_W-1:0]   begin_key;
		logic [KEY_W-1:0]   end_key;
		logic [VAL_W-1:0]   value;
		logic               ovf;
		logic               last;
		logic               tend;
	} route_beat_t;

	logic [KEY_W-1:0] kpw_reg;
	logic [WC_W-1:0]  wc_reg;
	route_beat_t      expected_beats[$];
	route_beat_t      run_beats[$];
	route_beat_t      want_beat;
	int               errors;
	int               beat_no;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h", beat_no, name, got, want));
	endtask

	// beats past the cap are dropped
	function automatic void put_beat(input longint unsigned shard, input cmd_t cmd,
			input longint unsigned b, input longint unsigned e, input longint unsigned v,
			input logic ovf);
		route_beat_t x;
		if (run_beats.size() >= RESULT_CAP)
			return;
		x.shard     = ovf ? '0 : SHARD_W'(shard);
		x.cmd       = cmd;
		x.begin_key = KEY_W'(b);
		x.end_key   = KEY_W'(e);
		x.value     = VAL_W'(v);
		x.ovf       = ovf;
		x.last      = 1'b0;
		x.tend      = 1'b0;
		run_beats.push_back(x);
	endfunction

	function automatic void route_op(input cmd_t cmd, input logic [KEY_W-1:0] klo,
			input logic [KEY_W-1:0] khi, input logic [VAL_W-1:0] val, input logic tl);
		longint unsigned kpw, wc, slo, shi, last_shard, s, b, e;
		run_beats.delete();
		kpw = (kpw_reg == '0) ? 1 : kpw_reg;
		wc  = (wc_reg > MAX_WORKERS) ? MAX_WORKERS : wc_reg;
		if (cmd == CMD_GET || cmd == CMD_PUT) begin
			slo = klo / kpw;
			put_beat(slo, cmd, klo, klo, (cmd == CMD_PUT) ? val : 0, slo >= wc);
		end else if (cmd == CMD_RANGE && klo <= khi) begin
			slo = klo / kpw;
			shi = khi / kpw;
			if (slo >= wc) begin
				put_beat(0, CMD_RANGE, klo, khi, 0, 1'b1);
			end else begin
				last_shard = (shi < wc) ? shi : wc - 1;
				for (s = slo; s <= last_shard; s++) begin
					b = s * kpw;
					e = b + kpw - 1;
					if (b < klo)
						b = klo;
					if (e > khi)
						e = khi;
					put_beat(s, CMD_RANGE, b, e, 0, 1'b0);
				end
				// tail of the range beyond the last shard in use
				if (shi >= wc)
					put_beat(0, CMD_RANGE, wc * kpw, khi, 0, 1'b1);
			end
		end
		if (run_beats.size() > 0) begin
			run_beats[run_beats.size() - 1].last = 1'b1;
			run_beats[run_beats.size() - 1].tend = tl;
		end
		while (run_beats.size() > 0)
			expected_beats.push_back(run_beats.pop_front());
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpw_reg = KPW_RESET;
			wc_reg  = WC_RESET;
			expected_beats.delete();
			errors  = 0;
			beat_no = 0;
			fail_count    <= 0;
			beats_pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_beats.size() == 0) begin
					report($sformatf("beat %0d with nothing expected: shard %0d cmd %0d keys 0x%0h..0x%0h",
						beat_no, rsp.shard_index, rsp.out_command, rsp.begin_key, rsp.end_key));
				end else begin
					want_beat = expected_beats.pop_front();
					check_field("shard_index", rsp.shard_index, want_beat.shard);
					check_field("out_command", rsp.out_command, want_beat.cmd);
					check_field("begin_key", rsp.begin_key, want_beat.begin_key);
					check_field("end_key", rsp.end_key, want_beat.end_key);
					check_field("out_value", rsp.out_value, want_beat.value);
					check_field("shard_overflow", rsp.shard_overflow, want_beat.ovf);
					check_field("run_last", rsp.run_last, want_beat.last);
					check_field("txn_end", rsp.txn_end, want_beat.tend);
				end
				beat_no++;
			end
			if (req.valid && req.ready)
				route_op(cmd_t'(req.command), req.key_low, req.key_high, req.put_value,
					req.txn_last);
			if (cfg_wr_en) begin
				if (cfg_index == REG_KPW)
					kpw_reg = cfg_data[KEY_W-1:0];
				else
					wc_reg = cfg_data[WC_W-1:0];
			end
			fail_count    <= errors;
			beats_pending <= expected_beats.size();
		end
	end

endmodule

[verif/key_range_partition_router_test.sv]
`timescale 1ns / 100ps
// top of the key range partition router testbench: clock, reset, register writes, operation
// stimulus and result back-pressure; the route checker beside the block gives the fail count
// depends on krp_pkg, krp_in_if, krp_out_if, krp_route_checker and the router itself
module key_range_partition_router_test;
	import krp_pkg::*;

	localparam longint unsigned KEY_MAX     = (longint'(1) << KEY_W) - 1;
	localparam int              LIMIT       = 600000;
	localparam int              HOLD_CYCLES = 300;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               fail_count;
	int               beats_pending;
	int               cycle_count;
	int               tx_idle;
	int               rx_idle;
	int               stall_req;
	int               stall_seen;
	int               hold_left;
	logic [KEY_W-1:0] stim_kpw;
	logic [WC_W-1:0]  stim_wc;

	krp_in_if  req_if();
	krp_out_if rsp_if();

	key_range_partition_router u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	krp_route_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_if),
		.rsp           (rsp_if),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.beats_pending (beats_pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, plus one long hold-off per request
	initial begin
		stall_seen = 0;
		hold_left  = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	function automatic longint unsigned eff_kpw();
		return (stim_kpw == '0) ? 1 : stim_kpw;
	endfunction

	// keys up to a quarter past the last shard in use
	function automatic longint unsigned key_span();
		longint unsigned wc, r;
		wc = (stim_wc > MAX_WORKERS) ? MAX_WORKERS : ((stim_wc == '0) ? 1 : stim_wc);
		r  = wc * eff_kpw();
		r  = r + r / 4;
		return (r > KEY_MAX) ? KEY_MAX : r;
	endfunction

	function automatic longint unsigned rand_below(input longint unsigned limit);
		return {$urandom(), $urandom()} % (limit + 1);
	endfunction

	task automatic send_op(input cmd_t cmd, input longint unsigned klo,
			input longint unsigned khi, input logic [VAL_W-1:0] val, input logic tl);
		while ($urandom_range(99) < tx_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.command   <= cmd;
		req_if.key_low   <= KEY_W'(klo);
		req_if.key_high  <= KEY_W'(khi);
		req_if.put_value <= val;
		req_if.txn_last  <= tl;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	// let every expected beat arrive, then cover an operation that gives none
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_config(input logic [KEY_W-1:0] kpw, input logic [WC_W-1:0] wc);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_KPW;
		cfg_data  <= kpw;
		@(posedge clk);
		// upper bits of the count write are junk that must be ignored
		cfg_index <= REG_WC;
		cfg_data  <= CFG_W'({$urandom(), wc});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		stim_kpw = kpw;
		stim_wc  = wc;
	endtask

	task automatic random_config();
		logic [KEY_W-1:0] kpw;
		logic [WC_W-1:0]  wc;
		case ($urandom_range(2))
			0:       kpw = KEY_W'($urandom_range(1, 8));
			1:       kpw = KEY_W'($urandom_range(9, 5000));
			default: kpw = KEY_W'($urandom());
		endcase
		if ($urandom_range(9) == 0)
			wc = WC_W'($urandom_range(31));
		else
			wc = WC_W'($urandom_range(1, 16));
		write_config(kpw, wc);
	endtask

	task automatic send_random_op();
		longint unsigned span, klo, khi;
		cmd_t            cmd;
		int              pick;
		span = key_span();
		pick = $urandom_range(99);
		if (pick < 25)
			cmd = CMD_GET;
		else if (pick < 50)
			cmd = CMD_PUT;
		else if (pick < 90)
			cmd = CMD_RANGE;
		else
			cmd = CMD_NONE;
		klo = ($urandom_range(6) == 0) ? rand_below(KEY_MAX) : rand_below(span);
		case ($urandom_range(9))
			0:       khi = rand_below(KEY_MAX);
			1:       khi = (klo > 0) ? rand_below(klo - 1) : 0;
			2:       khi = KEY_MAX;
			default: khi = klo + rand_below(eff_kpw() * $urandom_range(3));
		endcase
		if (khi > KEY_MAX)
			khi = KEY_MAX;
		send_op(cmd, klo, khi, $urandom(), $urandom_range(1));
	endtask

	initial begin
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.command   <= CMD_GET;
		req_if.key_low   <= '0;
		req_if.key_high  <= '0;
		req_if.put_value <= '0;
		req_if.txn_last  <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= REG_KPW;
		cfg_data         <= '0;
		stall_req        <= 0;
		rx_idle          <= 52;
		tx_idle  = 21;
		stim_kpw = KPW_RESET;
		stim_wc  = WC_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1024 keys per shard, 16 shards
		send_op(CMD_GET, 0, KEY_MAX, 32'hFFFF_FFFF, 1'b1);
		send_op(CMD_PUT, KEY_MAX, 0, 32'hFFFF_FFFF, 1'b0);
		send_op(CMD_PUT, 5000, 77, 32'hA5A5_5A5A, 1'b1);
		send_op(CMD_GET, 16383, 0, 32'h0, 1'b0);
		send_op(CMD_GET, 16384, 0, 32'h0, 1'b1);
		send_op(CMD_RANGE, 100, 100, 32'h1234_5678, 1'b0);
		send_op(CMD_RANGE, 1000, 3000, 32'h0, 1'b1);
		send_op(CMD_RANGE, 0, KEY_MAX, 32'h0, 1'b1);
		send_op(CMD_RANGE, 15000, 20000, 32'h0, 1'b0);
		send_op(CMD_RANGE, 20000, 30000, 32'h0, 1'b1);
		send_op(CMD_RANGE, 3000, 1000, 32'h0, 1'b1);
		send_op(CMD_NONE, 500, 600, 32'hFFFF_FFFF, 1'b1);
		send_op(CMD_RANGE, 1024, 2047, 32'h0, 1'b1);

		// smallest shards and a single worker
		settle();
		write_config(KEY_W'(1), WC_W'(1));
		send_op(CMD_GET, 0, 0, 32'h0, 1'b0);
		send_op(CMD_GET, 1, 0, 32'h0, 1'b1);
		send_op(CMD_RANGE, 0, 5, 32'h0, 1'b1);

		// largest shards
		settle();
		write_config(KEY_W'(KEY_MAX), WC_W'(16));
		send_op(CMD_RANGE, 0, KEY_MAX, 32'h0, 1'b1);
		send_op(CMD_PUT, KEY_MAX, KEY_MAX, 32'h0000_0001, 1'b1);

		// zero size acts as one, zero workers flags every key
		settle();
		write_config(KEY_W'(0), WC_W'(0));
		send_op(CMD_GET, 7, 0, 32'h0, 1'b1);
		send_op(CMD_RANGE, 3, 9, 32'h0, 1'b1);

		// worker count above the maximum, range long enough to hit the beat cap
		settle();
		write_config(KEY_W'(3), WC_W'(31));
		send_op(CMD_RANGE, 0, 100, 32'h0, 1'b1);
		send_op(CMD_GET, 47, 0, 32'h0, 1'b0);
		send_op(CMD_GET, 48, 0, 32'h0, 1'b1);

		// random phases: slow receiver, then slow sender, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle = 52;
				rx_idle <= 21;
			end else if (phase == 2) begin
				tx_idle = 0;
				rx_idle <= 0;
			end
			for (int blk = 0; blk < 2; blk++) begin
				settle();
				random_config();
				if (phase == 0 && blk == 0)
					stall_req <= stall_req + 1;
				repeat (52) send_random_op();
			end
		end

		settle();
		repeat (24) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
src/krp_pkg.sv
src/krp_in_if.sv
src/krp_out_if.sv
src/krp_divider.sv
src/krp_sequencer.sv
src/key_range_partition_router.sv
verif/krp_route_checker.sv
verif/key_range_partition_router_test.sv
